@@ design/t5ss_pkg.sv @@
// Shared constants and types for the top-five score selector.
package t5ss_pkg;

  // Width of the running index packed below the score in each key.
  localparam int INDEX_BITS = 16;
  // Width of an incoming class score.
  localparam int SCORE_BITS = 8;
  // Width of one key: score above, index below.
  localparam int KEY_BITS   = SCORE_BITS + INDEX_BITS;
  // Number of ranks kept in the sorted list.
  localparam int RANKS      = 5;
  // Width of each rank index on the result channel.
  localparam int RANK_BITS  = 16;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [RANK_BITS-1:0]  rank_index_t;

  // Highest running index; the counter stops here.
  localparam index_t INDEX_MAX = '1;

endpackage

@@ design/t5ss_score_if.sv @@
// Score channel and rank channel interfaces for the top-five score selector.
interface t5ss_score_if
  import t5ss_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [SCORE_BITS-1:0] score;
  logic                  last;

  modport source (output valid, output score, output last, input ready);
  modport sink   (input valid, input score, input last, output ready);
endinterface

interface t5ss_rank_if
  import t5ss_pkg::*;
;
  logic        valid;
  logic        ready;
  rank_index_t rank_one_index;
  rank_index_t rank_two_index;
  rank_index_t rank_three_index;
  rank_index_t rank_four_index;
  rank_index_t rank_five_index;

  modport source (output valid, output rank_one_index, output rank_two_index,
                  output rank_three_index, output rank_four_index,
                  output rank_five_index, input ready);
  modport sink   (input valid, input rank_one_index, input rank_two_index,
                  input rank_three_index, input rank_four_index,
                  input rank_five_index, output ready);
endinterface

@@ design/top5_score_selector_top.sv @@
// Top level of the top-five score selector: sorted list, index counter and result buffer.
//
// The block takes a stream of 8-bit class scores on score_ch, one score per
// transfer, with last marking the final score of a vector. Each score is tagged
// with its running index and kept if it ranks among the five best seen so far;
// equal scores favor the later index. On the transfer that carries last, the
// five best indexes, best first, are offered as one transfer on rank_ch, and
// the list and index counter start over for the next vector. Ranks that were
// never filled report index 0. The index counter sticks at its maximum.
//
// Throughput is one score per cycle while the holding stage is empty: all five
// compares of a new key against the list happen in parallel. The result for a
// vector is registered on rank_ch, or in the holding stage while rank_ch stalls.
//
// Reset (rst, synchronous, active high) empties the list, zeroes the counter
// and drops rank_ch.valid.
//
// When the receiver stalls rank_ch, the pending result holds in the output
// register and scores keep flowing. A second finished result parks in a
// holding stage; only while that stage is full does score_ch drop ready.
module top5_score_selector_top
  import t5ss_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  t5ss_score_if.sink   score_ch,
  t5ss_rank_if.source  rank_ch
);

  // Sorted list, best key at position zero, and the index for the next score.
  key_t        best_keys [RANKS];
  index_t      item_counter;

  // Output register and the holding stage behind it.
  logic        out_valid;
  rank_index_t out_idx   [RANKS];
  logic        skid_valid;
  rank_index_t skid_idx  [RANKS];

  key_t        new_key;
  logic        greater   [RANKS];
  key_t        keys_next [RANKS];
  rank_index_t rank_next [RANKS];
  index_t      item_counter_next;
  logic        score_accept;
  logic        rank_accept;
  logic        result_new;

  assign score_ch.ready = !skid_valid;
  assign score_accept   = score_ch.valid && score_ch.ready;
  assign rank_accept    = rank_ch.valid && rank_ch.ready;
  assign result_new     = score_accept && score_ch.last;

  // Insertion: the list is descending, so the strict compares form a run of
  // zeros followed by ones. The new key lands at the first position it beats
  // and everything from there down moves one place; the old fifth key drops.
  always_comb begin
    new_key = {score_ch.score, item_counter};
    for (int k = 0; k < RANKS; k++) begin
      greater[k] = new_key > best_keys[k];
    end
    if (greater[0]) begin
      keys_next[0] = new_key;
    end else begin
      keys_next[0] = best_keys[0];
    end
    for (int k = 1; k < RANKS; k++) begin
      if (!greater[k]) begin
        keys_next[k] = best_keys[k];
      end else if (!greater[k-1]) begin
        keys_next[k] = new_key;
      end else begin
        keys_next[k] = best_keys[k-1];
      end
    end
    for (int k = 0; k < RANKS; k++) begin
      rank_next[k] = RANK_BITS'(keys_next[k][INDEX_BITS-1:0]);
    end
    if (item_counter == INDEX_MAX) begin
      item_counter_next = item_counter;
    end else begin
      item_counter_next = item_counter + 1'b1;
    end
  end

  // List and counter: a last transfer starts the next vector from empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RANKS; k++) begin
        best_keys[k] <= '0;
      end
      item_counter <= '0;
    end else if (score_accept) begin
      if (score_ch.last) begin
        for (int k = 0; k < RANKS; k++) begin
          best_keys[k] <= '0;
        end
        item_counter <= '0;
      end else begin
        best_keys    <= keys_next;
        item_counter <= item_counter_next;
      end
    end
  end

  // Result buffer control. The holding stage fills only while the output
  // register is held, and drains into it as soon as that register frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !rank_accept) begin
      if (result_new) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= result_new;
    end
  end

  // Result payload, following the same decisions as the control above.
  always_ff @(posedge clk) begin
    if (out_valid && !rank_accept) begin
      if (result_new) begin
        skid_idx <= rank_next;
      end
    end else if (skid_valid) begin
      out_idx <= skid_idx;
    end else if (result_new) begin
      out_idx <= rank_next;
    end
  end

  assign rank_ch.valid            = out_valid;
  assign rank_ch.rank_one_index   = out_idx[0];
  assign rank_ch.rank_two_index   = out_idx[1];
  assign rank_ch.rank_three_index = out_idx[2];
  assign rank_ch.rank_four_index  = out_idx[3];
  assign rank_ch.rank_five_index  = out_idx[4];

endmodule

@@ design/t5ss_checker.sv @@
// Port-level assertions for the top-five score selector, bound to its top level.
module t5ss_checker
  import t5ss_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        score_valid,
  input logic        score_ready,
  input logic        score_last,
  input logic        rank_valid,
  input logic        rank_ready,
  input rank_index_t rank_one_index
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    rank_valid && !rank_ready |=> rank_valid)
    else $error("rank result withdrawn while stalled");

  // A stalled result keeps its best index.
  assert property (@(posedge clk) disable iff (rst)
    rank_valid && !rank_ready |=> $stable(rank_one_index))
    else $error("rank result changed while stalled");

  // With nothing pending, the last score of a vector gives a result next cycle.
  assert property (@(posedge clk) disable iff (rst)
    score_valid && score_ready && score_last && !rank_valid |=> rank_valid)
    else $error("no result after last score");

  // With nothing pending, a score that is not last gives no result.
  assert property (@(posedge clk) disable iff (rst)
    score_valid && score_ready && !score_last && !rank_valid |=> !rank_valid)
    else $error("result without last score");

  // Reset leaves no result offered.
  assert property (@(posedge clk) rst |=> !rank_valid)
    else $error("result offered after reset");

endmodule

bind top5_score_selector_top t5ss_checker u_t5ss_checker (
  .clk            (clk),
  .rst            (rst),
  .score_valid    (score_ch.valid),
  .score_ready    (score_ch.ready),
  .score_last     (score_ch.last),
  .rank_valid     (rank_ch.valid),
  .rank_ready     (rank_ch.ready),
  .rank_one_index (rank_ch.rank_one_index)
);
